### src/skvt_pkg.sv
// shared types, codes and defaults for the sorted key/value table
`timescale 1ns / 1ps
package skvt_pkg;

  localparam int unsigned CapacityDef   = 64;
  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned KeyWidthDef   = 32;
  // cells per or-reduction group
  localparam int unsigned GroupSize     = 8;
  localparam int unsigned CountOutWidth = 7;

  localparam logic [1:0] KIND_ATTACH = 2'd0;
  localparam logic [1:0] KIND_DETACH = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_ABSENT = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] key;
    logic [31:0]        value;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [31:0]              read_value;
    logic [CountOutWidth-1:0] entry_count;
  } out_t;

  typedef struct packed {
    logic ins;
    logic rem;
    logic wr;
  } apply_t;

endpackage

### src/skvt_cell.sv
// one table slot: holds a key/value pair, compares it and shifts with its neighbors
`timescale 1ns / 1ps
module skvt_cell #(
  parameter int unsigned KW  = 32,
  parameter int unsigned VW  = 32,
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmp_en_i,
  input  logic [KW-1:0]      cmp_key_i,
  input  logic [CW-1:0]      count_i,
  input  skvt_pkg::apply_t   apply_i,
  input  logic [KW-1:0]      new_key_i,
  input  logic [VW-1:0]      new_val_i,
  input  logic [KW-1:0]      left_key_i,
  input  logic [VW-1:0]      left_val_i,
  input  logic               left_lt_i,
  input  logic [KW-1:0]      right_key_i,
  input  logic [VW-1:0]      right_val_i,
  output logic [KW-1:0]      key_o,
  output logic [VW-1:0]      val_o,
  output logic               lt_o,
  output logic               eq_o
);
  import skvt_pkg::*;

  logic [KW-1:0] key_q, key_d;
  logic [VW-1:0] val_q, val_d;
  logic          lt_q, lt_d, eq_q, eq_d;
  logic          occupied;

  always_comb begin
    occupied = CW'(IDX) < count_i;
    lt_d     = lt_q;
    eq_d     = eq_q;
    if (cmp_en_i) begin
      lt_d = occupied && ($signed(key_q) < $signed(cmp_key_i));
      eq_d = occupied && (key_q == cmp_key_i);
    end
  end

  // slots from the boundary on shift; an insert puts the new pair at the boundary
  always_comb begin
    key_d = key_q;
    val_d = val_q;
    if (apply_i.ins && !lt_q) begin
      if (left_lt_i) begin
        key_d = new_key_i;
        val_d = new_val_i;
      end else begin
        key_d = left_key_i;
        val_d = left_val_i;
      end
    end else if (apply_i.rem && !lt_q) begin
      key_d = right_key_i;
      val_d = right_val_i;
    end else if (apply_i.wr && eq_q) begin
      val_d = new_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

  assign key_o = key_q;
  assign val_o = val_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

### src/skvt_group.sv
// registered or-reduction of match flags and matched values over one group of slots
`timescale 1ns / 1ps
module skvt_group #(
  parameter int unsigned GW = 8,
  parameter int unsigned VW = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [GW-1:0]         eq_i,
  input  logic [GW-1:0][VW-1:0] val_i,
  output logic                  hit_o,
  output logic [VW-1:0]         val_o
);
  import skvt_pkg::*;

  logic          hit_q, hit_d;
  logic [VW-1:0] val_q, val_d;

  always_comb begin
    hit_d = |eq_i;
    val_d = '0;
    for (int i = 0; i < GW; i++) begin
      val_d = val_d | (val_i[i] & {VW{eq_i[i]}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign hit_o = hit_q;
  assign val_o = val_q;

endmodule

### src/sorted_key_value_table_core.sv
// sorted key/value table: one input beat in, one status beat out
//
// in channel carries kind, signed key and value; out channel returns status,
// read value and the entry count after the operation. Both channels use
// valid/stall; a beat moves when valid is high and stall is low.
// Entries live in a chain of CAPACITY slots kept in ascending key order.
// On the accepting edge every slot compares its key with the incoming key.
// The next cycle reduces the match flags and values in groups of eight, and
// the apply step after it resolves the outcome, shifts the chain one slot
// up for an insert or one slot down for a removal, and loads the output
// register. A new item is taken only after the previous one has run
// through the compare / reduce / apply sequence.
// in_stall_o is high while an item is in flight. A waiting result does not
// block the next accept; only the apply step holds while out_stall_i keeps
// the previous result in the output register.
// Reset empties the table and clears out_valid_o; slot contents are not
// cleared, the entry count alone marks which slots hold entries.
`timescale 1ns / 1ps
module sorted_key_value_table_core #(
  parameter int unsigned CAPACITY    = skvt_pkg::CapacityDef,
  parameter int unsigned VALUE_WIDTH = skvt_pkg::ValueWidthDef,
  parameter int unsigned KEY_WIDTH   = skvt_pkg::KeyWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  skvt_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output skvt_pkg::out_t out_data_o
);
  import skvt_pkg::*;

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned NGRP = (CAPACITY + GroupSize - 1) / GroupSize;
  localparam int unsigned NPAD = NGRP * GroupSize;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RED   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]    state_q, state_d;
  in_t           op_q;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  logic                   accept;
  logic                   go;
  logic                   hit;
  logic                   full;
  logic [VALUE_WIDTH-1:0] rd;
  apply_t                 apply;

  logic [KEY_WIDTH-1:0]   cmp_key;
  logic [KEY_WIDTH-1:0]   new_key;
  logic [VALUE_WIDTH-1:0] new_val;

  logic [KEY_WIDTH-1:0]   key_a [CAPACITY];
  logic [VALUE_WIDTH-1:0] val_a [CAPACITY];
  logic [CAPACITY-1:0]    lt_a;
  logic [CAPACITY-1:0]    eq_a;

  logic [NPAD-1:0]                  eq_pad;
  logic [NPAD-1:0][VALUE_WIDTH-1:0] val_pad;
  logic [NGRP-1:0]                  grp_hit;
  logic [VALUE_WIDTH-1:0]           grp_val [NGRP];

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  assign cmp_key = in_data_i.key[KEY_WIDTH-1:0];
  assign new_key = op_q.key[KEY_WIDTH-1:0];
  assign new_val = VALUE_WIDTH'(op_q.value);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_WIDTH-1:0]   lk, rk;
    logic [VALUE_WIDTH-1:0] lv, rv;
    logic                   llt;

    if (g == 0) begin : g_first
      assign lk  = '0;
      assign lv  = '0;
      assign llt = 1'b1;
    end else begin : g_mid
      assign lk  = key_a[g-1];
      assign lv  = val_a[g-1];
      assign llt = lt_a[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign rk = '0;
      assign rv = '0;
    end else begin : g_next
      assign rk = key_a[g+1];
      assign rv = val_a[g+1];
    end

    skvt_cell #(
      .KW (KEY_WIDTH),
      .VW (VALUE_WIDTH),
      .IDX(g),
      .CW (CW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmp_en_i   (accept),
      .cmp_key_i  (cmp_key),
      .count_i    (count_q),
      .apply_i    (apply),
      .new_key_i  (new_key),
      .new_val_i  (new_val),
      .left_key_i (lk),
      .left_val_i (lv),
      .left_lt_i  (llt),
      .right_key_i(rk),
      .right_val_i(rv),
      .key_o      (key_a[g]),
      .val_o      (val_a[g]),
      .lt_o       (lt_a[g]),
      .eq_o       (eq_a[g])
    );
  end

  for (genvar p = 0; p < NPAD; p++) begin : g_pad
    if (p < CAPACITY) begin : g_used
      assign eq_pad[p]  = eq_a[p];
      assign val_pad[p] = val_a[p];
    end else begin : g_spare
      assign eq_pad[p]  = 1'b0;
      assign val_pad[p] = '0;
    end
  end

  for (genvar r = 0; r < NGRP; r++) begin : g_grp
    skvt_group #(
      .GW(GroupSize),
      .VW(VALUE_WIDTH)
    ) u_group (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .eq_i  (eq_pad[r*GroupSize +: GroupSize]),
      .val_i (val_pad[r*GroupSize +: GroupSize]),
      .hit_o (grp_hit[r]),
      .val_o (grp_val[r])
    );
  end

  always_comb begin
    hit = |grp_hit;
    rd  = '0;
    for (int i = 0; i < NGRP; i++) begin
      rd = rd | grp_val[i];
    end
  end

  assign full = (count_q == CW'(CAPACITY));
  // apply waits only while the previous result is still held
  assign go   = (state_q == ST_APPLY) && !(out_valid_q && out_stall_i);

  always_comb begin
    apply.ins = go && (op_q.kind == KIND_ATTACH) && !hit && !full;
    apply.wr  = go && (op_q.kind == KIND_ATTACH) && hit;
    apply.rem = go && (op_q.kind == KIND_DETACH) && hit;
  end

  always_comb begin
    count_d = count_q;
    if (go && (op_q.kind == KIND_CLEAR)) begin
      count_d = '0;
    end else if (apply.ins) begin
      count_d = count_q + CW'(1);
    end else if (apply.rem) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    out_d            = out_q;
    out_d.status     = STATUS_OK;
    out_d.read_value = '0;
    case (op_q.kind)
      KIND_ATTACH: begin
        if (!hit && full) begin
          out_d.status = STATUS_FULL;
        end
      end
      KIND_DETACH: begin
        if (!hit) begin
          out_d.status = STATUS_ABSENT;
        end
      end
      KIND_LOOKUP: begin
        if (hit) begin
          out_d.read_value = 32'(rd);
        end else begin
          out_d.status = STATUS_ABSENT;
        end
      end
      default: begin
        out_d.status = STATUS_OK;
      end
    endcase
    out_d.entry_count = CountOutWidth'(count_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (go) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RED;
        end
      end
      ST_RED: begin
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_data_i;
    end
    if (go) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RED) ##1 (state_q == ST_APPLY))
    else $error("accepted item did not enter reduce and apply");

  a_result_from_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_APPLY))
    else $error("result raised outside apply");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && (out_d.status == STATUS_FULL)) |-> full && (count_d == count_q))
    else $error("full status with room or a count change");

endmodule
